// ----- rtl/oaid_pkg.sv -----
// Package for the ordered array insert/delete block.
// Holds the table depth, field widths, command and status codes and the cell control type.
// No dependencies.
package oaid_pkg;

  localparam int DEPTH   = 16;
  localparam int IDX_W   = $clog2(DEPTH);
  localparam int CNT_W   = $clog2(DEPTH + 1);
  localparam int DATA_W  = 32;
  localparam int CMD_W   = 2;
  localparam int STAT_W  = 2;

  localparam logic [CMD_W-1:0] CMD_INSERT = 2'd0;
  localparam logic [CMD_W-1:0] CMD_DELETE = 2'd1;
  localparam logic [CMD_W-1:0] CMD_READ   = 2'd2;

  localparam logic [STAT_W-1:0] STATUS_OK    = 2'd0;
  localparam logic [STAT_W-1:0] STATUS_RANGE = 2'd1;
  localparam logic [STAT_W-1:0] STATUS_FULL  = 2'd2;

  typedef enum logic [1:0] {
    CELL_HOLD       = 2'd0,
    CELL_LOAD_VALUE = 2'd1,
    CELL_SHIFT_UP   = 2'd2,
    CELL_SHIFT_DOWN = 2'd3
  } cell_op_t;

  typedef struct packed {
    cell_op_t op;
  } cell_ctrl_t;

endpackage

// ----- rtl/oaid_if.sv -----
// Channel interfaces for the ordered array insert/delete block.
// Command channel and result channel, each a valid/ready transaction with payload.
// Depends on oaid_pkg.
interface oaid_cmd_if import oaid_pkg::*; ();
  logic                     valid;
  logic                     ready;
  logic [CMD_W-1:0]         cmd;
  logic [CNT_W-1:0]         position;
  logic signed [DATA_W-1:0] value;

  modport source (output valid, cmd, position, value, input ready);
  modport sink (input valid, cmd, position, value, output ready);
endinterface

interface oaid_res_if import oaid_pkg::*; ();
  logic                     valid;
  logic                     ready;
  logic [STAT_W-1:0]        status;
  logic [CNT_W-1:0]         entry_count;
  logic [CNT_W-1:0]         removed_count;
  logic signed [DATA_W-1:0] read_value;

  modport source (output valid, status, entry_count, removed_count, read_value, input ready);
  modport sink (input valid, status, entry_count, removed_count, read_value, output ready);
endinterface

// ----- rtl/oaid_cell.sv -----
// One storage cell of the ordered table row.
// Holds one entry, loads from either neighbor or the new value, and compares against a key.
// Depends on oaid_pkg.
module oaid_cell import oaid_pkg::*; (
  input  logic                     clk,
  input  cell_ctrl_t               ctrl,
  input  logic signed [DATA_W-1:0] left,
  input  logic signed [DATA_W-1:0] right,
  input  logic signed [DATA_W-1:0] load_data,
  input  logic signed [DATA_W-1:0] key,
  output logic signed [DATA_W-1:0] data,
  output logic                     match
);

  always_ff @(posedge clk) begin
    unique case (ctrl.op)
      CELL_LOAD_VALUE: data <= load_data;
      CELL_SHIFT_UP:   data <= left;
      CELL_SHIFT_DOWN: data <= right;
      CELL_HOLD:       data <= data;
      default:         data <= data;
    endcase
  end

  assign match = (data == key);

endmodule

// ----- rtl/ordered_array_insert_delete.sv -----
// Top level of the ordered array insert/delete block.
// Instantiates a row of oaid_cell and the command sequencer; uses oaid_pkg and oaid_if.
// An insert or read command's result is registered as the command is accepted.
// A delete walks the row with a single compare-and-shift step: a match pulls every higher
// cell down and keeps the scan slot, a miss advances it, and the result is posted once the
// scan reaches the live count and the result channel is free. One command is in flight at a
// time, and a new one can be taken in the cycle its predecessor's result is taken. The table
// contents have no reset; only slots below the live count are ever read.
module ordered_array_insert_delete import oaid_pkg::*; (
  input logic           clk,
  input logic           rst,
  oaid_cmd_if.sink      cmd_ch,
  oaid_res_if.source    res_ch
);

  typedef enum logic [1:0] {
    ST_IDLE   = 2'b01,
    ST_DELETE = 2'b10
  } state_t;

  state_t                   state;
  logic [CNT_W-1:0]         count;
  logic [CNT_W-1:0]         scan;
  logic [CNT_W-1:0]         removed;
  logic signed [DATA_W-1:0] key;

  logic                     res_valid;
  logic [STAT_W-1:0]        res_status;
  logic [CNT_W-1:0]         res_count;
  logic [CNT_W-1:0]         res_removed;
  logic signed [DATA_W-1:0] res_read;

  logic signed [DATA_W-1:0] cell_data [DEPTH];
  logic [DEPTH-1:0]         cell_match;
  cell_ctrl_t               cell_ctrl [DEPTH];

  logic accept;
  logic res_free;
  logic ins_ok;
  logic rd_ok;
  logic scan_live;
  logic hit;

  assign res_free  = !res_valid || res_ch.ready;
  assign cmd_ch.ready = (state == ST_IDLE) && res_free;
  assign accept    = cmd_ch.valid && cmd_ch.ready;
  assign ins_ok    = (cmd_ch.position <= count) && (count < CNT_W'(DEPTH));
  assign rd_ok     = (cmd_ch.position < count);
  assign scan_live = (scan < count);
  assign hit       = cell_match[scan[IDX_W-1:0]];

  // Per-cell control: insert opens a gap at the position in one step; delete closes
  // the slot under the scan pointer by pulling every higher cell down.
  always_comb begin
    for (int j = 0; j < DEPTH; j++) begin
      cell_ctrl[j].op = CELL_HOLD;
      if (accept && cmd_ch.cmd == CMD_INSERT && ins_ok) begin
        if (CNT_W'(j) == cmd_ch.position) begin
          cell_ctrl[j].op = CELL_LOAD_VALUE;
        end else if (CNT_W'(j) > cmd_ch.position) begin
          cell_ctrl[j].op = CELL_SHIFT_UP;
        end
      end else if (state == ST_DELETE && scan_live && hit && CNT_W'(j) >= scan) begin
        cell_ctrl[j].op = CELL_SHIFT_DOWN;
      end
    end
  end

  for (genvar g = 0; g < DEPTH; g++) begin : g_cell
    logic signed [DATA_W-1:0] left_data;
    logic signed [DATA_W-1:0] right_data;

    if (g == 0) begin : g_first
      assign left_data = cmd_ch.value;
    end else begin : g_mid_left
      assign left_data = cell_data[g-1];
    end

    if (g == DEPTH - 1) begin : g_last
      assign right_data = cell_data[g];
    end else begin : g_mid_right
      assign right_data = cell_data[g+1];
    end

    oaid_cell u_cell (
      .clk       (clk),
      .ctrl      (cell_ctrl[g]),
      .left      (left_data),
      .right     (right_data),
      .load_data (cmd_ch.value),
      .key       (key),
      .data      (cell_data[g]),
      .match     (cell_match[g])
    );
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      count     <= '0;
      scan      <= '0;
      removed   <= '0;
      res_valid <= 1'b0;
    end else begin
      if (res_valid && res_ch.ready) begin
        res_valid <= 1'b0;
      end
      unique case (state)
        ST_IDLE: begin
          if (accept) begin
            res_removed <= '0;
            res_read    <= '0;
            res_status  <= STATUS_OK;
            res_count   <= count;
            res_valid   <= 1'b1;
            priority if (cmd_ch.cmd == CMD_INSERT) begin
              if (cmd_ch.position > count) begin
                res_status <= STATUS_RANGE;
              end else if (count >= CNT_W'(DEPTH)) begin
                res_status <= STATUS_FULL;
              end else begin
                count     <= count + 1'b1;
                res_count <= count + 1'b1;
              end
            end else if (cmd_ch.cmd == CMD_DELETE) begin
              // The result is posted when the scan finishes.
              res_valid <= 1'b0;
              key       <= cmd_ch.value;
              scan      <= '0;
              removed   <= '0;
              state     <= ST_DELETE;
            end else if (cmd_ch.cmd == CMD_READ) begin
              if (rd_ok) begin
                res_read <= cell_data[cmd_ch.position[IDX_W-1:0]];
              end else begin
                res_status <= STATUS_RANGE;
              end
            end else begin
              res_status <= STATUS_OK;
            end
          end
        end
        ST_DELETE: begin
          if (scan_live) begin
            if (hit) begin
              count   <= count - 1'b1;
              removed <= removed + 1'b1;
            end else begin
              scan <= scan + 1'b1;
            end
          end else if (res_free) begin
            res_valid   <= 1'b1;
            res_status  <= STATUS_OK;
            res_count   <= count;
            res_removed <= removed;
            res_read    <= '0;
            state       <= ST_IDLE;
          end
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

  assign res_ch.valid         = res_valid;
  assign res_ch.status        = res_status;
  assign res_ch.entry_count   = res_count;
  assign res_ch.removed_count = res_removed;
  assign res_ch.read_value    = res_read;

  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= CNT_W'(DEPTH))
    else $error("live count exceeds table depth");

  a_scan_bound: assert property (@(posedge clk) disable iff (rst)
    state == ST_DELETE |-> scan <= count)
    else $error("delete scan pointer passed the live count");

  a_insert_grows: assert property (@(posedge clk) disable iff (rst)
    accept && cmd_ch.cmd == CMD_INSERT && ins_ok |=> count == CNT_W'($past(count) + 1'b1))
    else $error("accepted insert did not grow the table by one");

  a_delete_shrinks: assert property (@(posedge clk) disable iff (rst)
    state == ST_DELETE && scan_live && hit |=>
      count == CNT_W'($past(count) - 1'b1) && removed == CNT_W'($past(removed) + 1'b1))
    else $error("delete match did not move one entry from count to removed");

endmodule

// ----- bench/tb.sv -----
// Testbench for ordered_array_insert_delete: random and directed table commands are checked
// against a behavioral model of the table. The model lives in a small scoreboard class.
// Depends on oaid_pkg, oaid_if and the block's RTL.
`timescale 1ns / 1ps

module tb import oaid_pkg::*; ();

  localparam logic [CMD_W-1:0] CMD_UNUSED = 2'd3;
  localparam logic signed [DATA_W-1:0] VAL_MIN = {1'b1, {(DATA_W-1){1'b0}}};
  localparam logic signed [DATA_W-1:0] VAL_MAX = {1'b0, {(DATA_W-1){1'b1}}};
  localparam int CYCLE_LIMIT = 600000;
  localparam int PHASES = 10;
  localparam int PHASE_ITEMS = 152;

  typedef struct {
    logic [STAT_W-1:0]        status;
    logic [CNT_W-1:0]         entry_count;
    logic [CNT_W-1:0]         removed_count;
    logic signed [DATA_W-1:0] read_value;
  } reply_t;

  class table_scoreboard;
    logic signed [DATA_W-1:0] slots [DEPTH];
    int unsigned live;
    reply_t      pending_replies [$];
    int          errors;
    int          replies_checked;
    int          cmd_seen [4];
    int          status_seen [4];
    int          most_removed;
    int          full_hits;

    function new();
      live = 0;
      errors = 0;
      replies_checked = 0;
      most_removed = 0;
      full_hits = 0;
      foreach (cmd_seen[i]) cmd_seen[i] = 0;
      foreach (status_seen[i]) status_seen[i] = 0;
    endfunction

    function int outstanding();
      return pending_replies.size();
    endfunction

    // Applies one accepted command to the table copy and queues the reply it must produce.
    function void note_command(logic [CMD_W-1:0] cmd, logic [CNT_W-1:0] pos,
                               logic signed [DATA_W-1:0] value);
      reply_t      want;
      int unsigned kept;
      want.status        = STATUS_OK;
      want.removed_count = '0;
      want.read_value    = '0;
      case (cmd)
        CMD_INSERT: begin
          if (pos > live) begin
            want.status = STATUS_RANGE;
          end else if (live >= DEPTH) begin
            want.status = STATUS_FULL;
          end else begin
            for (int i = live; i > pos; i--) slots[i] = slots[i-1];
            slots[pos] = value;
            live++;
            if (live == DEPTH) full_hits++;
          end
        end
        CMD_DELETE: begin
          kept = 0;
          for (int i = 0; i < live; i++) begin
            if (slots[i] == value) begin
              want.removed_count++;
            end else begin
              slots[kept] = slots[i];
              kept++;
            end
          end
          live = kept;
          if (want.removed_count > most_removed) most_removed = want.removed_count;
        end
        CMD_READ: begin
          if (pos >= live) want.status = STATUS_RANGE;
          else want.read_value = slots[pos];
        end
        default: ;
      endcase
      want.entry_count = CNT_W'(live);
      cmd_seen[cmd]++;
      status_seen[want.status]++;
      pending_replies.push_back(want);
    endfunction

    task report_mismatch(string msg);
      errors++;
      $display("[%0t] error %0d: %s", $time, errors, msg);
    endtask

    task check_result(reply_t got);
      reply_t want;
      if (pending_replies.size() == 0) begin
        report_mismatch($sformatf("reply with no command outstanding (status %0d count %0d)",
                                  got.status, got.entry_count));
        return;
      end
      want = pending_replies.pop_front();
      replies_checked++;
      if (got.status !== want.status)
        report_mismatch($sformatf("reply %0d status %0d, want %0d",
                                  replies_checked, got.status, want.status));
      if (got.entry_count !== want.entry_count)
        report_mismatch($sformatf("reply %0d entry_count %0d, want %0d",
                                  replies_checked, got.entry_count, want.entry_count));
      if (got.removed_count !== want.removed_count)
        report_mismatch($sformatf("reply %0d removed_count %0d, want %0d",
                                  replies_checked, got.removed_count, want.removed_count));
      if (got.read_value !== want.read_value)
        report_mismatch($sformatf("reply %0d read_value %0d, want %0d",
                                  replies_checked, got.read_value, want.read_value));
    endtask
  endclass

  logic clk = 1'b0;
  logic rst;
  int   tx_max_gap = 0;
  int   rx_max_stall = 0;
  int   cycle_count = 0;
  table_scoreboard sb;

  oaid_cmd_if cmd_ch ();
  oaid_res_if res_ch ();

  ordered_array_insert_delete i_dut (
    .clk    (clk),
    .rst    (rst),
    .cmd_ch (cmd_ch),
    .res_ch (res_ch)
  );

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d replies still due", cycle_count, sb.outstanding());
      $display("SCOREBOARD MISMATCH");
      $finish;
    end
  end

  // Holds valid high across back-to-back commands; only a gap or a reply drain drops it.
  task send_command(logic [CMD_W-1:0] cmd, logic [CNT_W-1:0] pos,
                    logic signed [DATA_W-1:0] value);
    int gap;
    gap = $urandom_range(0, tx_max_gap);
    if (gap > 0) begin
      cmd_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    cmd_ch.valid    <= 1'b1;
    cmd_ch.cmd      <= cmd;
    cmd_ch.position <= pos;
    cmd_ch.value    <= value;
    do @(posedge clk); while (cmd_ch.ready !== 1'b1);
    sb.note_command(cmd, pos, value);
  endtask

  task wait_replies_done();
    cmd_ch.valid <= 1'b0;
    while (sb.outstanding() != 0) @(posedge clk);
  endtask

  // Result side: random stall before each reply, then hold ready until the transaction.
  initial begin
    reply_t got;
    int     stall;
    res_ch.ready <= 1'b0;
    while (rst !== 1'b0) @(posedge clk);
    forever begin
      stall = $urandom_range(0, rx_max_stall);
      if (stall > 0) begin
        res_ch.ready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      res_ch.ready <= 1'b1;
      do @(posedge clk); while (res_ch.valid !== 1'b1);
      got.status        = res_ch.status;
      got.entry_count   = res_ch.entry_count;
      got.removed_count = res_ch.removed_count;
      got.read_value    = res_ch.read_value;
      sb.check_result(got);
    end
  end

  initial begin
    logic [CMD_W-1:0]         c;
    logic [CNT_W-1:0]         p;
    logic signed [DATA_W-1:0] v;
    logic signed [DATA_W-1:0] pool [4];
    logic signed [DATA_W-1:0] fill_vals [16];
    int                       roll;
    int                       pool_n;
    int                       ins_w;
    int                       del_w;
    sb = new();
    cmd_ch.valid    <= 1'b0;
    cmd_ch.cmd      <= CMD_INSERT;
    cmd_ch.position <= '0;
    cmd_ch.value    <= '0;
    rst             <= 1'b1;
    repeat (12) @(posedge clk);
    rst <= 1'b0;

    // Empty table: out-of-range reads and inserts, a delete that finds nothing, unused code.
    tx_max_gap   = 3;
    rx_max_stall = 3;
    send_command(CMD_READ, 5'd0, '0);
    send_command(CMD_READ, 5'd31, VAL_MAX);
    send_command(CMD_INSERT, 5'd1, 32'sd9);
    send_command(CMD_INSERT, 5'd31, VAL_MIN);
    send_command(CMD_DELETE, 5'd0, '0);
    send_command(CMD_UNUSED, 5'd31, -32'sd1);

    // Fill to capacity through front, back and middle inserts, with adjacent duplicates.
    fill_vals = '{VAL_MIN, 32'sd5, VAL_MAX, 32'sd5, 32'sd5, 32'sd0, -32'sd1, 32'sd5,
                  32'sd1, 32'sh5555_5555, 32'shAAAA_AAAA, 32'sd5, -32'sd2, 32'sd5,
                  32'sd7, 32'sd5};
    for (int k = 0; k < DEPTH; k++) begin
      if (k % 3 == 0) p = '0;
      else if (k % 3 == 1) p = CNT_W'(k);
      else p = CNT_W'(k / 2);
      send_command(CMD_INSERT, p, fill_vals[k]);
    end
    send_command(CMD_INSERT, 5'd16, 32'sd3);
    send_command(CMD_INSERT, 5'd17, 32'sd3);
    send_command(CMD_READ, 5'd15, '0);
    send_command(CMD_READ, 5'd16, '0);
    send_command(CMD_DELETE, 5'd0, 32'sd5);
    send_command(CMD_DELETE, 5'd0, 32'sd12345);
    send_command(CMD_READ, 5'd0, '0);
    wait_replies_done();

    for (int phase = 0; phase < PHASES; phase++) begin
      tx_max_gap   = (phase == 0 || phase == 5) ? 0 : ((phase % 2 == 1) ? 16 : 4);
      rx_max_stall = (phase == 0 || phase == 7) ? 0 : ((phase % 3 == 0) ? 4 : 16);
      pool_n = $urandom_range(1, 4);
      for (int i = 0; i < 4; i++)
        pool[i] = ($urandom_range(0, 1) == 1) ? $urandom : int'($urandom_range(0, 8)) - 4;
      // Phases rotate between filling, balanced and emptying command mixes.
      ins_w = (phase % 3 == 0) ? 60 : ((phase % 3 == 1) ? 40 : 25);
      del_w = (phase % 3 == 0) ? 10 : ((phase % 3 == 1) ? 20 : 40);
      for (int n = 0; n < PHASE_ITEMS; n++) begin
        roll = $urandom_range(0, 99);
        if (roll < ins_w) c = CMD_INSERT;
        else if (roll < ins_w + del_w) c = CMD_DELETE;
        else if (roll < 95) c = CMD_READ;
        else c = CMD_UNUSED;
        p = CNT_W'(($urandom_range(0, 4) == 0) ? $urandom_range(0, 31)
                                                : $urandom_range(0, sb.live));
        roll = $urandom_range(0, 9);
        if (c == CMD_DELETE && sb.live > 0 && roll < 8)
          v = sb.slots[$urandom_range(0, sb.live - 1)];
        else if (roll < 6) v = pool[$urandom_range(0, pool_n - 1)];
        else if (roll < 7) v = ($urandom_range(0, 1) == 1) ? VAL_MIN : VAL_MAX;
        else v = $urandom;
        send_command(c, p, v);
      end
      if (phase % 3 == 2) wait_replies_done();
    end

    wait_replies_done();
    repeat (2 * DEPTH) @(posedge clk);
    $display("%0d replies checked: %0d inserts, %0d deletes, %0d reads, %0d unused codes",
             sb.replies_checked, sb.cmd_seen[CMD_INSERT], sb.cmd_seen[CMD_DELETE],
             sb.cmd_seen[CMD_READ], sb.cmd_seen[CMD_UNUSED]);
    $display("status ok/range/full %0d/%0d/%0d, table full %0d times, largest delete %0d",
             sb.status_seen[STATUS_OK], sb.status_seen[STATUS_RANGE],
             sb.status_seen[STATUS_FULL], sb.full_hits, sb.most_removed);
    if (sb.errors == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule
